/* src/ssse3_pkg.sv */
// ----------------------------------------------------------------------------
// SSSE3 ALU package
// Operation codes shared by the datapath, the top level and the checker.
// ----------------------------------------------------------------------------
package ssse3_pkg;

  typedef enum logic [3:0] {
    KIND_PSIGNB    = 4'd0,
    KIND_PSIGNW    = 4'd1,
    KIND_PSIGND    = 4'd2,
    KIND_PABSB     = 4'd3,
    KIND_PABSW     = 4'd4,
    KIND_PABSD     = 4'd5,
    KIND_PALIGNR   = 4'd6,
    KIND_PSHUFB    = 4'd7,
    KIND_PMULHRSW  = 4'd8,
    KIND_PMADDUBSW = 4'd9,
    KIND_PHSUBW    = 4'd10,
    KIND_PHSUBD    = 4'd11,
    KIND_PHSUBSW   = 4'd12,
    KIND_PHADDW    = 4'd13,
    KIND_PHADDD    = 4'd14,
    KIND_PHADDSW   = 4'd15
  } kind_t;

  localparam int VEC_W   = 128;
  localparam int HALF_W  = 64;
  localparam int KIND_W  = 4;
  localparam int IMM_W   = 8;

endpackage

/* src/ssse3_alu_core.sv */
// ----------------------------------------------------------------------------
// SSSE3 ALU datapath
// Lane arithmetic for all sixteen operations and the result select.
// ----------------------------------------------------------------------------
module ssse3_alu_core (
  input  ssse3_pkg::kind_t                  kind,
  input  logic [ssse3_pkg::VEC_W-1:0]       dst,
  input  logic [ssse3_pkg::VEC_W-1:0]       src,
  input  logic [ssse3_pkg::IMM_W-1:0]       imm,
  output logic [ssse3_pkg::VEC_W-1:0]       result
);
  import ssse3_pkg::*;

  function automatic logic [15:0] sat16(input logic [17:0] v);
    logic [15:0] r;
    if (!v[17] && (v[16:15] != 2'b00)) begin
      r = 16'h7fff;
    end else if (v[17] && (v[16:15] != 2'b11)) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic [VEC_W-1:0]   sign_b, sign_w, sign_d;
  logic [VEC_W-1:0]   abs_b, abs_w, abs_d;
  logic [VEC_W-1:0]   align_res, shuf_res, mulhrs_res, madd_res;
  logic [VEC_W-1:0]   hsub_w, hsub_d, hsubs_w, hadd_w, hadd_d, hadds_w;
  logic [2*VEC_W-1:0] pairs;
  logic [2*VEC_W-1:0] align_cat;
  logic [2*VEC_W-1:0] align_shift;

  // horizontal pairs: destination pairs first, then source pairs
  assign pairs     = {src, dst};
  assign align_cat = {dst, src};
  assign align_shift = align_cat >> {imm[4:0], 3'b000};
  assign align_res   = (imm[7:5] == 3'd0) ? align_shift[VEC_W-1:0] : '0;

  for (genvar i = 0; i < 16; i++) begin : g_byte
    logic [7:0] d8, s8;
    assign d8 = dst[8*i +: 8];
    assign s8 = src[8*i +: 8];
    assign sign_b[8*i +: 8] = s8[7] ? 8'(~d8 + 8'd1) : ((s8 == 8'd0) ? 8'd0 : d8);
    assign abs_b[8*i +: 8]  = s8[7] ? 8'(~s8 + 8'd1) : s8;
    assign shuf_res[8*i +: 8] = s8[7] ? 8'd0 : dst[{s8[3:0], 3'b000} +: 8];
  end

  for (genvar i = 0; i < 8; i++) begin : g_word
    logic [15:0]        d16, s16, ha, hb;
    logic signed [31:0] prod;
    logic [17:0]        rnd;
    logic signed [16:0] mp0, mp1;
    logic [17:0]        msum;
    logic [17:0]        hs, hd;
    assign d16 = dst[16*i +: 16];
    assign s16 = src[16*i +: 16];
    assign sign_w[16*i +: 16] = s16[15] ? 16'(~d16 + 16'd1)
                                        : ((s16 == 16'd0) ? 16'd0 : d16);
    assign abs_w[16*i +: 16]  = s16[15] ? 16'(~s16 + 16'd1) : s16;

    assign prod = $signed(d16) * $signed(s16);
    assign rnd  = 18'(prod[31:14] + 18'd1);
    assign mulhrs_res[16*i +: 16] = rnd[16:1];

    assign mp0  = $signed({1'b0, d16[7:0]}) * $signed(s16[7:0]);
    assign mp1  = $signed({1'b0, d16[15:8]}) * $signed(s16[15:8]);
    assign msum = {mp0[16], mp0} + {mp1[16], mp1};
    assign madd_res[16*i +: 16] = sat16(msum);

    assign ha = pairs[32*i +: 16];
    assign hb = pairs[32*i+16 +: 16];
    assign hs = {{2{ha[15]}}, ha} + {{2{hb[15]}}, hb};
    assign hd = {{2{ha[15]}}, ha} - {{2{hb[15]}}, hb};
    assign hadd_w[16*i +: 16]  = hs[15:0];
    assign hsub_w[16*i +: 16]  = hd[15:0];
    assign hadds_w[16*i +: 16] = sat16(hs);
    assign hsubs_w[16*i +: 16] = sat16(hd);
  end

  for (genvar i = 0; i < 4; i++) begin : g_dword
    logic [31:0] d32, s32, ha, hb;
    assign d32 = dst[32*i +: 32];
    assign s32 = src[32*i +: 32];
    assign sign_d[32*i +: 32] = s32[31] ? 32'(~d32 + 32'd1)
                                        : ((s32 == 32'd0) ? 32'd0 : d32);
    assign abs_d[32*i +: 32]  = s32[31] ? 32'(~s32 + 32'd1) : s32;
    assign ha = pairs[64*i +: 32];
    assign hb = pairs[64*i+32 +: 32];
    assign hadd_d[32*i +: 32] = ha + hb;
    assign hsub_d[32*i +: 32] = ha - hb;
  end

  always_comb begin
    case (kind)
      KIND_PSIGNB:    result = sign_b;
      KIND_PSIGNW:    result = sign_w;
      KIND_PSIGND:    result = sign_d;
      KIND_PABSB:     result = abs_b;
      KIND_PABSW:     result = abs_w;
      KIND_PABSD:     result = abs_d;
      KIND_PALIGNR:   result = align_res;
      KIND_PSHUFB:    result = shuf_res;
      KIND_PMULHRSW:  result = mulhrs_res;
      KIND_PMADDUBSW: result = madd_res;
      KIND_PHSUBW:    result = hsub_w;
      KIND_PHSUBD:    result = hsub_d;
      KIND_PHSUBSW:   result = hsubs_w;
      KIND_PHADDW:    result = hadd_w;
      KIND_PHADDD:    result = hadd_d;
      KIND_PHADDSW:   result = hadds_w;
      default:        result = '0;
    endcase
  end

endmodule

/* src/ssse3_packed_integer_alu.sv */
// ----------------------------------------------------------------------------
// SSSE3 packed integer ALU, 128-bit forms
// Sign, abs, align, shuffle, rounded multiply, multiply-add and horizontal
// add/subtract on two 128-bit operands.
//
// Usage:
//   Raise start with in_kind, the two operands and in_shift_bytes. A transfer
//   happens at each rising edge where start is high and busy is low. busy is
//   low whenever rst_n is high, so one operation is taken every cycle.
//   The operation is captured in an input register and computed by one pass
//   of lane logic into the result register: out_valid pulses for one cycle
//   as the result register is loaded, with out_result_low/out_result_high.
//   Throughput 1 operation per cycle while rst_n is high; the lane multipliers
//   of the rounded multiply and multiply-add set the critical path.
//   The receiver cannot stall: each result is shown for exactly one cycle.
//   Reset (synchronous, rst_n low) drops any operation in flight and holds
//   busy high.
// ----------------------------------------------------------------------------
module ssse3_packed_integer_alu (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [ssse3_pkg::KIND_W-1:0]      in_kind,
  input  logic [ssse3_pkg::HALF_W-1:0]      in_dst_low,
  input  logic [ssse3_pkg::HALF_W-1:0]      in_dst_high,
  input  logic [ssse3_pkg::HALF_W-1:0]      in_src_low,
  input  logic [ssse3_pkg::HALF_W-1:0]      in_src_high,
  input  logic [ssse3_pkg::IMM_W-1:0]       in_shift_bytes,
  output logic                              out_valid,
  output logic [ssse3_pkg::HALF_W-1:0]      out_result_low,
  output logic [ssse3_pkg::HALF_W-1:0]      out_result_high
);
  import ssse3_pkg::*;

  logic              in_valid_r;
  kind_t             kind_r;
  logic [VEC_W-1:0]  dst_r, src_r;
  logic [IMM_W-1:0]  imm_r;
  logic [VEC_W-1:0]  result_nxt, result_r;
  logic              out_valid_r;
  logic              accept;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= accept;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind_t'(in_kind);
      dst_r  <= {in_dst_high, in_dst_low};
      src_r  <= {in_src_high, in_src_low};
      imm_r  <= in_shift_bytes;
    end
    if (in_valid_r) begin
      result_r <= result_nxt;
    end
  end

  ssse3_alu_core u_core (
    .kind   (kind_r),
    .dst    (dst_r),
    .src    (src_r),
    .imm    (imm_r),
    .result (result_nxt)
  );

  assign out_valid       = out_valid_r;
  assign out_result_low  = result_r[HALF_W-1:0];
  assign out_result_high = result_r[VEC_W-1:HALF_W];

endmodule

/* src/ssse3_checker.sv */
// ----------------------------------------------------------------------------
// SSSE3 ALU checker
// Port-level checks of result timing and of zeroing cases, bound to the top.
// ----------------------------------------------------------------------------
module ssse3_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic [ssse3_pkg::KIND_W-1:0]      in_kind,
  input  logic [ssse3_pkg::HALF_W-1:0]      in_src_low,
  input  logic [ssse3_pkg::HALF_W-1:0]      in_src_high,
  input  logic [ssse3_pkg::IMM_W-1:0]       in_shift_bytes,
  input  logic                              out_valid,
  input  logic [ssse3_pkg::HALF_W-1:0]      out_result_low,
  input  logic [ssse3_pkg::HALF_W-1:0]      out_result_high
);
  import ssse3_pkg::*;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("transfer not followed by a result two cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 2))
    else $error("result without a matching transfer");

  a_shuffle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_kind == KIND_PSHUFB)
     && ((in_src_low & 64'h8080808080808080) == 64'h8080808080808080)
     && ((in_src_high & 64'h8080808080808080) == 64'h8080808080808080))
    |-> ##2 (out_result_low == 64'd0 && out_result_high == 64'd0))
    else $error("shuffle with all high selector bits not zero");

  a_align_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_kind == KIND_PALIGNR) && (in_shift_bytes[7:5] != 3'd0))
    |-> ##2 (out_result_low == 64'd0 && out_result_high == 64'd0))
    else $error("align past 32 bytes not zero");

endmodule

bind ssse3_packed_integer_alu ssse3_checker u_checker (.*);
